// ===== hdl/htfr_pkg.sv =====
// Package: shared widths, configuration register indexes and the result record.
package htfr_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_HEADER_BYTE = 2'd0;
  localparam cfg_idx_t CFG_TRAILER_FIRST = 2'd1;
  localparam cfg_idx_t CFG_TRAILER_SECOND = 2'd2;

  // Position of the first byte after the header or after a counter wrap.
  localparam byte_t POS_FIRST = 8'd1;
  // Trailer bytes removed from the position to give the payload length.
  localparam byte_t TRAILER_LEN = 8'd2;

  typedef struct packed {
    logic  byte_stored;
    byte_t store_position;
    byte_t stored_value;
    logic  frame_done;
    byte_t payload_length;
  } result_t;

endpackage

// ===== hdl/header_trailer_frame_receiver_unit.sv =====
// Top level: header/trailer byte deframer with an output register stage.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    in_rx_byte
//   out      output     out_valid / out_ready  out_byte_stored, out_store_position,
//                                              out_stored_value, out_frame_done,
//                                              out_payload_length
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Every accepted byte produces exactly one result in the following cycle, and a
// new byte can be taken in every cycle while the single output register is not stalled.
// Reset (rst_n low, synchronous) returns the block to hunting, clears the
// position counter, the last stored byte and all three configuration registers.
// When the output register holds a result that has not been taken, in_ready
// drops until out_ready frees it; the output side then stalls the input side.
// The configuration port is always ready.
module header_trailer_frame_receiver_unit import htfr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  // Input byte channel.
  input  logic     in_valid,
  output logic     in_ready,
  input  byte_t    in_rx_byte,
  // Result channel.
  output logic     out_valid,
  input  logic     out_ready,
  output logic     out_byte_stored,
  output byte_t    out_store_position,
  output byte_t    out_stored_value,
  output logic     out_frame_done,
  output byte_t    out_payload_length,
  // Configuration write channel.
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  byte_t    cfg_data
);

  // Configuration registers.
  byte_t header_byte_r;
  byte_t trailer_first_r;
  byte_t trailer_second_r;

  // Framing state.
  logic  in_frame_r, in_frame_nxt;
  byte_t byte_count_r, byte_count_nxt;
  byte_t previous_byte_r, previous_byte_nxt;

  // Output register.
  logic    out_valid_r;
  result_t result_r, result_nxt;

  logic in_xfer;
  logic cfg_xfer;
  byte_t pos;
  logic done;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid & cfg_ready;

  // The output register can take a new result when it is empty or being emptied.
  assign in_ready = ~out_valid_r | out_ready;
  assign in_xfer  = in_valid & in_ready;

  // Position of this byte if it is stored; wraps modulo 256.
  assign pos = byte_count_r + POS_FIRST;

  // The trailer test is skipped at position one so that a stale previous byte
  // from an earlier frame can never close a frame on its first byte.
  assign done = in_frame_r && (pos != POS_FIRST) && (in_rx_byte == trailer_second_r)
                && (previous_byte_r == trailer_first_r);

  always_comb begin
    in_frame_nxt      = in_frame_r;
    byte_count_nxt    = byte_count_r;
    previous_byte_nxt = previous_byte_r;
    result_nxt        = '0;
    if (!in_frame_r) begin
      // Hunting: the header byte itself is not stored and yields an all-zero result.
      if (in_rx_byte == header_byte_r) begin
        in_frame_nxt   = 1'b1;
        byte_count_nxt = '0;
      end
    end else begin
      result_nxt.byte_stored    = 1'b1;
      result_nxt.store_position = pos;
      result_nxt.stored_value   = in_rx_byte;
      previous_byte_nxt         = in_rx_byte;
      if (done) begin
        result_nxt.frame_done     = 1'b1;
        result_nxt.payload_length = pos - TRAILER_LEN;
        in_frame_nxt              = 1'b0;
        byte_count_nxt            = '0;
      end else begin
        byte_count_nxt = pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_byte_r    <= '0;
      trailer_first_r  <= '0;
      trailer_second_r <= '0;
    end else if (cfg_xfer) begin
      case (cfg_index)
        CFG_HEADER_BYTE:    header_byte_r    <= cfg_data;
        CFG_TRAILER_FIRST:  trailer_first_r  <= cfg_data;
        CFG_TRAILER_SECOND: trailer_second_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r      <= 1'b0;
      byte_count_r    <= '0;
      previous_byte_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_frame_r      <= in_frame_nxt;
        byte_count_r    <= byte_count_nxt;
        previous_byte_r <= previous_byte_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload holds while a transfer is stalled; no reset needed.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte_stored    = result_r.byte_stored;
  assign out_store_position = result_r.store_position;
  assign out_stored_value   = result_r.stored_value;
  assign out_frame_done     = result_r.frame_done;
  assign out_payload_length = result_r.payload_length;

endmodule

// ===== hdl/htfr_checker.sv =====
// Checker: port-level assertions for the deframer, bound to the top level.
module htfr_checker import htfr_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  out_valid,
  input logic  out_ready,
  input logic  out_byte_stored,
  input byte_t out_store_position,
  input byte_t out_stored_value,
  input logic  out_frame_done,
  input byte_t out_payload_length
);

  // A stalled result keeps its position, value and frame-end flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_store_position)
      && $stable(out_stored_value) && $stable(out_frame_done))
    else $error("result changed while stalled");

  // A hunting byte reports nothing.
  a_hunt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_stored |-> out_store_position == '0
      && out_stored_value == '0 && !out_frame_done && out_payload_length == '0)
    else $error("unstored byte carries data");

  // The frame end is always a stored byte, never at position one.
  a_done_stored: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_byte_stored && out_store_position != POS_FIRST)
    else $error("frame end on an unstored byte or at position one");

  // The payload length excludes the two trailer bytes.
  a_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |->
      out_payload_length == byte_t'(out_store_position - TRAILER_LEN))
    else $error("payload length does not match position");

  // Without a frame end the length stays zero.
  a_length_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_done |-> out_payload_length == '0)
    else $error("length reported without frame end");

endmodule

bind header_trailer_frame_receiver_unit htfr_checker u_htfr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_byte_stored   (out_byte_stored),
  .out_store_position(out_store_position),
  .out_stored_value  (out_stored_value),
  .out_frame_done    (out_frame_done),
  .out_payload_length(out_payload_length)
);

// ===== dv/tb_top.sv =====
// Testbench for the header/trailer byte deframer: random traffic checked against a local predictor.
`timescale 1ns / 1ps

module tb_top;
  import htfr_pkg::*;

  // A transfer-free stretch this long means the block is hung. Receiver stalls
  // are geometric at 73 percent, so a stall that reaches the limit is
  // practically impossible; the limit leaves a wide margin.
  localparam int unsigned STALL_LIMIT = 2000;
  // Random bytes queued per configuration setting before switching to the next one.
  localparam int unsigned SEGMENT_BYTES = 120;
  localparam int unsigned SEGMENT_COUNT = 8;
  // Mismatch lines beyond this are counted but not printed.
  localparam int unsigned PRINT_CAP = 100;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  byte_t    in_rx_byte = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  logic     out_byte_stored;
  byte_t    out_store_position;
  byte_t    out_stored_value;
  logic     out_frame_done;
  byte_t    out_payload_length;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index = '0;
  byte_t    cfg_data = '0;

  header_trailer_frame_receiver_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte_stored    (out_byte_stored),
    .out_store_position (out_store_position),
    .out_stored_value   (out_stored_value),
    .out_frame_done     (out_frame_done),
    .out_payload_length (out_payload_length),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Bytes waiting to be sent, and the results the predictor says must come back.
  byte_t       rx_bytes_pending[$];
  result_t     results_due[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_sent = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Idle percentages for the sending and receiving sides of the block.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Predictor copy of the block's registers and framing state.
  byte_t cfg_header = '0;
  byte_t cfg_trail1 = '0;
  byte_t cfg_trail2 = '0;
  logic  frame_open = 1'b0;
  byte_t run_pos = '0;
  byte_t last_stored = '0;

  // Register values the stimulus generator builds frames from.
  byte_t gen_header = '0;
  byte_t gen_trail1 = '0;
  byte_t gen_trail2 = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Computes the result for one accepted byte and advances the framing state.
  // While hunting, the header only opens the frame and nothing is stored. Inside
  // a frame, the byte at position one is never tested against the trailer; this
  // holds both right after the header and after the position counter wraps.
  function automatic result_t deframe_byte(byte_t rx);
    result_t r;
    byte_t   pos;
    r = '0;
    if (!frame_open) begin
      if (rx == cfg_header) begin
        frame_open = 1'b1;
        run_pos = '0;
      end
      return r;
    end
    pos = run_pos + 8'd1;
    r.byte_stored = 1'b1;
    r.store_position = pos;
    r.stored_value = rx;
    if (pos != POS_FIRST && rx == cfg_trail2 && last_stored == cfg_trail1) begin
      r.frame_done = 1'b1;
      r.payload_length = pos - TRAILER_LEN;
      frame_open = 1'b0;
      run_pos = '0;
    end else begin
      run_pos = pos;
    end
    last_stored = rx;
    return r;
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("%0t: %s mismatch: got %0d, expected %0d", $time, field, got, want);
    end
  endtask

  // Sender. A transfer on the byte channel feeds the predictor at the same edge;
  // configuration transfers update its register copy. A new byte is offered only
  // when the channel is free after this edge, so valid never drops under a byte.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_header = '0;
      cfg_trail1 = '0;
      cfg_trail2 = '0;
      frame_open = 1'b0;
      run_pos = '0;
      last_stored = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HEADER_BYTE:    cfg_header = cfg_data;
          CFG_TRAILER_FIRST:  cfg_trail1 = cfg_data;
          CFG_TRAILER_SECOND: cfg_trail2 = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        results_due.push_back(deframe_byte(in_rx_byte));
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (rx_bytes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_rx_byte <= rx_bytes_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Each result transfer is checked field by field against the oldest
  // prediction; ready is redrawn every cycle.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result, stored_value", out_stored_value, 0);
        end else begin
          want = results_due.pop_front();
          if (out_byte_stored !== want.byte_stored)
            report_mismatch("byte_stored", out_byte_stored, want.byte_stored);
          if (out_store_position !== want.store_position)
            report_mismatch("store_position", out_store_position, want.store_position);
          if (out_stored_value !== want.stored_value)
            report_mismatch("stored_value", out_stored_value, want.stored_value);
          if (out_frame_done !== want.frame_done)
            report_mismatch("frame_done", out_frame_done, want.frame_done);
          if (out_payload_length !== want.payload_length)
            report_mismatch("payload_length", out_payload_length, want.payload_length);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: any transfer on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_byte(byte_t b);
    rx_bytes_pending.push_back(b);
    bytes_queued++;
  endtask

  // Header, payload, then both trailer bytes. With lead_t2 set, the first
  // payload byte equals the second trailer byte to probe the position-one rule.
  task automatic push_frame(int unsigned len, bit lead_t2);
    int unsigned i;
    push_byte(gen_header);
    for (i = 0; i < len; i++) begin
      if (i == 0 && lead_t2) push_byte(gen_trail2);
      else push_byte(byte_t'($urandom));
    end
    push_byte(gen_trail1);
    push_byte(gen_trail2);
  endtask

  // Waits until every queued byte has been sent and every result has come back,
  // then lets the output stage settle before the registers are touched.
  task automatic drain();
    do @(posedge clk); while (bytes_sent != bytes_queued || results_due.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, byte_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  task automatic set_config(byte_t hdr, byte_t tr1, byte_t tr2);
    write_reg(CFG_HEADER_BYTE, hdr);
    write_reg(CFG_TRAILER_FIRST, tr1);
    write_reg(CFG_TRAILER_SECOND, tr2);
    cfg_valid <= 1'b0;
    gen_header = hdr;
    gen_trail1 = tr1;
    gen_trail2 = tr2;
  endtask

  // One segment of random traffic. Most of it is well-formed frames with random
  // payload; the rest is line noise, frames cut short before the trailer and
  // stray trailer bytes. A long frame, when asked for, runs the position counter
  // through its wrap: the trailer lands on position 255, on position 0 (payload
  // length 254), or straddles the wrap so that it sits on position one and
  // must be ignored.
  task automatic random_segment(bit long_frame);
    int unsigned first;
    int unsigned pick;
    int unsigned n;
    int unsigned i;
    first = bytes_queued;
    if (long_frame) begin
      case ($urandom_range(3))
        0: push_frame(253, 1'b0);
        1: push_frame(254, 1'b0);
        2: push_frame(255, 1'b0);
        default: push_frame($urandom_range(256, 300), 1'b0);
      endcase
    end
    while (bytes_queued - first < SEGMENT_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        n = ($urandom_range(3) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        push_frame(n, $urandom_range(7) == 0);
      end else if (pick < 80) begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(3) == 0) push_byte(gen_header);
          else push_byte(byte_t'($urandom));
        end
      end else if (pick < 90) begin
        // Truncated frame: the trailer stops after its first byte.
        push_byte(gen_header);
        n = $urandom_range(0, 8);
        for (i = 0; i < n; i++) push_byte(byte_t'($urandom));
        push_byte(gen_trail1);
      end else begin
        if ($urandom_range(1) == 0) push_byte(gen_trail1);
        push_byte(gen_trail2);
      end
    end
  endtask

  // Main sequence: reset, a directed part under three register settings, then
  // random segments, each under a setting of its own. The sender and receiver
  // idle first 24/73 percent, then 73/24, and finally not at all.
  initial begin : stimulus
    int unsigned seg;
    byte_t       v;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 24;
    recv_idle_pct = 73;

    // All registers still at reset value zero: a zero byte opens a frame, the
    // byte at position one is not a trailer even though it matches, and the
    // next zero closes a frame of payload length zero.
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'hFF);
    drain();

    // Distinct header and trailer values: noise while hunting, a normal frame,
    // the shortest frame, and a header value inside a frame that is only data.
    set_config(8'hA5, 8'h3C, 8'hC3);
    push_byte(8'h5A);
    push_byte(8'hA5);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h3C);
    push_byte(8'hC3);
    push_byte(8'hC3);
    push_byte(8'hA5);
    push_byte(8'h3C);
    push_byte(8'hC3);
    push_byte(8'hA5);
    push_byte(8'hA5);
    push_byte(8'hC3);
    push_byte(8'h3C);
    push_byte(8'h3C);
    push_byte(8'hC3);
    drain();

    // Equal trailer bytes: after a frame the last stored byte already matches
    // the first trailer byte, so only the position-one rule keeps the next
    // frame from ending on its first byte.
    set_config(8'h7E, 8'h81, 8'h81);
    push_byte(8'h7E);
    push_byte(8'h81);
    push_byte(8'h81);
    push_byte(8'h7E);
    push_byte(8'h81);
    push_byte(8'h81);

    for (seg = 0; seg < SEGMENT_COUNT; seg++) begin
      drain();
      if (seg == 3) begin
        send_idle_pct = 73;
        recv_idle_pct = 24;
      end else if (seg == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      v = byte_t'($urandom);
      case (seg)
        0: set_config(8'hFF, 8'hFF, 8'hFF);
        4: set_config(8'h00, 8'hFF, 8'h00);
        6: set_config(v, v, v);
        default: begin
          // Odd segments share one value between the trailer bytes.
          if (seg % 2 == 1) set_config(byte_t'($urandom), v, v);
          else set_config(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
        end
      endcase
      random_segment(seg % 3 == 1);
    end

    drain();
    repeat (3) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/htfr_pkg.sv
hdl/header_trailer_frame_receiver_unit.sv
hdl/htfr_checker.sv
dv/tb_top.sv
